// File: design/decimal_string_to_scaled_integer_assert.svh
// Assertion helpers used by the RTL of the decimal parser.
`ifndef DECIMAL_STRING_TO_SCALED_INTEGER_ASSERT_SVH
`define DECIMAL_STRING_TO_SCALED_INTEGER_ASSERT_SVH

// Checked at every rising clock edge, switched off while reset is held.
`define DSI_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked at every rising clock edge, reset included.
`define DSI_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/dsi_pkg.sv
package dsi_pkg;

  localparam int unsigned MaxDecimalsDefault = 9;
  localparam int unsigned ValueW = 32;
  localparam int unsigned CountW = 4;
  localparam int unsigned CharW  = 8;

  localparam logic [CharW-1:0] CharPlus  = 8'h2B;
  localparam logic [CharW-1:0] CharMinus = 8'h2D;
  localparam logic [CharW-1:0] CharPoint = 8'h2E;
  localparam logic [CharW-1:0] CharZero  = 8'h30;
  localparam logic [CharW-1:0] CharNine  = 8'h39;
  localparam logic [3:0]       RoundHalf = 4'd5;

  typedef enum logic [1:0] {
    StOk    = 2'd0,
    StBad   = 2'd1,
    StRange = 2'd2
  } status_e;

  // Everything the finishing pipeline needs about one completed string.
  typedef struct packed {
    logic              neg;
    logic [ValueW-1:0] mag;
    logic              ovf;
    logic [CountW-1:0] pad;
    logic              round_up;
    logic              bad;
  } dsi_snap_t;

  typedef struct packed {
    logic s1;
    logic s2;
  } dsi_pipe_t;

  function automatic logic [ValueW-1:0] pow10(input logic [CountW-1:0] n);
    logic [ValueW-1:0] r;
    case (n)
      4'd0:    r = 32'd1;
      4'd1:    r = 32'd10;
      4'd2:    r = 32'd100;
      4'd3:    r = 32'd1000;
      4'd4:    r = 32'd10000;
      4'd5:    r = 32'd100000;
      4'd6:    r = 32'd1000000;
      4'd7:    r = 32'd10000000;
      4'd8:    r = 32'd100000000;
      4'd9:    r = 32'd1000000000;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

// File: design/dsi_in_if.sv
interface dsi_in_if;
  import dsi_pkg::*;

  logic             valid;
  logic             ready;
  logic [CharW-1:0] char_byte;
  logic             has_char;
  logic             last;

  modport source (output valid, output char_byte, output has_char, output last, input ready);
  modport sink (input valid, input char_byte, input has_char, input last, output ready);
endinterface

// File: design/dsi_out_if.sv
interface dsi_out_if;
  import dsi_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [ValueW-1:0] scaled_value;
  logic [1:0]               status;

  modport source (output valid, output scaled_value, output status, input ready);
  modport sink (input valid, input scaled_value, input status, output ready);
endinterface

// File: design/decimal_string_to_scaled_integer.sv
// After the last item is accepted, its result passes the s1 and s2 registers to the output.
// Throughput: one item per cycle unless out_o stalls; multiply-by-ten-and-add decides this.
// The three finishing stages (snapshot, pad multiply, round and range check) stall together.
// Reset: rst_ni clears the parser state, all stage valid bits and frac_digits to zero.
// No clearing pass is needed after reset; the block takes items at the first clock edge.
module decimal_string_to_scaled_integer import dsi_pkg::*; #(
  parameter int unsigned MaxDecimals = MaxDecimalsDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CountW-1:0] cfg_wdata_i,
  dsi_in_if.sink            in_i,
  dsi_out_if.source         out_o
);

  // The frac_digits register. Values above MaxDecimals are clamped where they are used.
  logic [CountW-1:0] frac_q;
  logic [CountW-1:0] dec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frac_q <= '0;
    end else if (cfg_we_i) begin
      frac_q <= cfg_wdata_i;
    end
  end

  assign dec = (frac_q > CountW'(MaxDecimals)) ? CountW'(MaxDecimals) : frac_q;

  // The whole pipeline advances whenever the output register is empty or is being
  // drained, so a new item enters each cycle while results flow out.
  logic      adv;
  logic      acc;
  dsi_snap_t snap;
  dsi_pipe_t pipe;

  assign adv        = !out_o.valid || out_o.ready;
  assign in_i.ready = adv;
  assign acc        = in_i.valid && adv;

  // Character parser: holds the per-string state and, on the last item, hands a
  // snapshot of the finished string to the back end.
  dsi_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (acc),
    .char_byte_i (in_i.char_byte),
    .has_char_i  (in_i.has_char),
    .last_i      (in_i.last),
    .dec_i       (dec),
    .snap_o      (snap)
  );

  // Back end: scales by the missing power of ten, rounds half away from zero,
  // checks the signed 32-bit range and registers the result.
  dsi_finish #(
    .MaxDecimals (MaxDecimals)
  ) u_finish (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (adv),
    .vld_i     (acc && in_i.last),
    .snap_i    (snap),
    .out_vld_o (out_o.valid),
    .value_o   (out_o.scaled_value),
    .status_o  (out_o.status),
    .pipe_o    (pipe)
  );

`include "decimal_string_to_scaled_integer_assert.svh"

  // Any failing conversion reports zero as its value.
  `DSI_ASSERT(a_err_zero, clk_i, rst_ni, out_o.valid && (out_o.status != StOk) |-> out_o.scaled_value == '0, "error result carries a nonzero value")
  // An accepted last item always enters the first finishing stage.
  `DSI_ASSERT(a_last_enters, clk_i, rst_ni, in_i.valid && in_i.ready && in_i.last |=> pipe.s1, "last item did not reach the finishing pipeline")
  // A result only appears when the middle stage held one.
  `DSI_ASSERT(a_out_source, clk_i, rst_ni, $rose(out_o.valid) |-> $past(pipe.s2), "result appeared without a string behind it")
  // Only the three defined status codes ever leave the block. While reset is held
  // the output register may not have settled yet, so the check starts after it.
  `DSI_ASSERT_ALWAYS(a_status_code, clk_i, !rst_ni || !out_o.valid || (out_o.status <= StRange), "reserved status code on output")

endmodule

// File: design/dsi_parse.sv
module dsi_parse import dsi_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              acc_i,
  input  logic [CharW-1:0]  char_byte_i,
  input  logic              has_char_i,
  input  logic              last_i,
  input  logic [CountW-1:0] dec_i,
  output dsi_snap_t         snap_o
);

  typedef enum logic [3:0] {
    PhStart = 4'b0001,
    PhInt   = 4'b0010,
    PhFrac  = 4'b0100,
    PhBad   = 4'b1000
  } phase_e;

  phase_e            phase_q, phase_n, phase_d;
  logic              neg_q, neg_n, neg_d;
  logic [ValueW-1:0] mag_q, mag_n, mag_d;
  logic              ovf_q, ovf_n, ovf_d;
  logic [CountW-1:0] kept_q, kept_n, kept_d;
  logic              rnd_seen_q, rnd_seen_n, rnd_seen_d;
  logic              rnd_up_q, rnd_up_n, rnd_up_d;
  logic              seen_q, seen_n, seen_d;

  logic              is_digit;
  logic [3:0]        digit;
  logic [ValueW+3:0] times_ten;
  logic              push_sat;
  logic [ValueW-1:0] pushed;

  assign is_digit = (char_byte_i >= CharZero) && (char_byte_i <= CharNine);
  assign digit    = char_byte_i[3:0];

  // Multiply by ten as two shifts and an add, saturating at all ones.
  assign times_ten = ({4'b0, mag_q} << 3) + ({4'b0, mag_q} << 1) + {32'b0, digit};
  assign push_sat  = |times_ten[ValueW+3:ValueW];
  assign pushed    = push_sat ? '1 : times_ten[ValueW-1:0];

  always_comb begin
    phase_n    = phase_q;
    neg_n      = neg_q;
    mag_n      = mag_q;
    ovf_n      = ovf_q;
    kept_n     = kept_q;
    rnd_seen_n = rnd_seen_q;
    rnd_up_n   = rnd_up_q;
    seen_n     = seen_q;
    if (acc_i && has_char_i) begin
      case (phase_q)
        PhStart: begin
          if (char_byte_i == CharPlus || char_byte_i == CharMinus) begin
            neg_n   = (char_byte_i == CharMinus);
            phase_n = PhInt;
          end else if (char_byte_i == CharPoint) begin
            phase_n = PhFrac;
          end else if (is_digit) begin
            mag_n   = pushed;
            ovf_n   = ovf_q | push_sat;
            seen_n  = 1'b1;
            phase_n = PhInt;
          end else begin
            phase_n = PhBad;
          end
        end
        PhInt: begin
          if (is_digit) begin
            mag_n  = pushed;
            ovf_n  = ovf_q | push_sat;
            seen_n = 1'b1;
          end else if (char_byte_i == CharPoint) begin
            phase_n = PhFrac;
          end else begin
            phase_n = PhBad;
          end
        end
        PhFrac: begin
          if (is_digit) begin
            if (kept_q < dec_i) begin
              mag_n  = pushed;
              ovf_n  = ovf_q | push_sat;
              kept_n = kept_q + 4'd1;
            end else if (!rnd_seen_q) begin
              rnd_seen_n = 1'b1;
              rnd_up_n   = (digit >= RoundHalf);
            end
            seen_n = 1'b1;
          end else begin
            phase_n = PhBad;
          end
        end
        default: begin
          phase_n = PhBad;
        end
      endcase
    end
  end

  always_comb begin
    snap_o.neg      = neg_n;
    snap_o.mag      = mag_n;
    snap_o.ovf      = ovf_n;
    snap_o.pad      = (dec_i > kept_n) ? (dec_i - kept_n) : '0;
    snap_o.round_up = rnd_up_n;
    snap_o.bad      = (phase_n == PhBad) || !seen_n;
  end

  // The last item of a string hands its state on and starts a fresh string.
  always_comb begin
    if (acc_i && last_i) begin
      phase_d    = PhStart;
      neg_d      = 1'b0;
      mag_d      = '0;
      ovf_d      = 1'b0;
      kept_d     = '0;
      rnd_seen_d = 1'b0;
      rnd_up_d   = 1'b0;
      seen_d     = 1'b0;
    end else begin
      phase_d    = phase_n;
      neg_d      = neg_n;
      mag_d      = mag_n;
      ovf_d      = ovf_n;
      kept_d     = kept_n;
      rnd_seen_d = rnd_seen_n;
      rnd_up_d   = rnd_up_n;
      seen_d     = seen_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhStart;
      neg_q      <= 1'b0;
      mag_q      <= '0;
      ovf_q      <= 1'b0;
      kept_q     <= '0;
      rnd_seen_q <= 1'b0;
      rnd_up_q   <= 1'b0;
      seen_q     <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      neg_q      <= neg_d;
      mag_q      <= mag_d;
      ovf_q      <= ovf_d;
      kept_q     <= kept_d;
      rnd_seen_q <= rnd_seen_d;
      rnd_up_q   <= rnd_up_d;
      seen_q     <= seen_d;
    end
  end

endmodule

// File: design/dsi_finish.sv
module dsi_finish import dsi_pkg::*; #(
  parameter int unsigned MaxDecimals = MaxDecimalsDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     vld_i,
  input  dsi_snap_t                snap_i,
  output logic                     out_vld_o,
  output logic signed [ValueW-1:0] value_o,
  output logic [1:0]               status_o,
  output dsi_pipe_t                pipe_o
);

  localparam int unsigned Pow10W = $clog2((10 ** MaxDecimals) + 1);
  localparam int unsigned ProdW  = ValueW + Pow10W;

  logic              s1_vld_q, s2_vld_q, out_vld_q;
  dsi_snap_t         s1_q;
  logic              s2_neg_q, s2_ovf_q, s2_rup_q, s2_bad_q;
  logic [ValueW-1:0] s2_mag_q;

  logic [Pow10W-1:0] scale;
  logic [ProdW-1:0]  prod;
  logic              prod_ovf;

  logic [ValueW:0]   rounded;
  logic [ValueW:0]   limit;
  status_e           status_d;
  logic [ValueW-1:0] value_d;
  status_e           status_q;
  logic [ValueW-1:0] value_q;

  // Stage two: pad the missing fraction digits with one multiply.
  assign scale    = Pow10W'(pow10(s1_q.pad));
  assign prod     = s1_q.mag * scale;
  assign prod_ovf = |prod[ProdW-1:ValueW];

  // Stage three: round, range check, apply the sign.
  assign rounded = {1'b0, s2_mag_q} + {{ValueW{1'b0}}, s2_rup_q};
  assign limit   = s2_neg_q ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;

  always_comb begin
    if (s2_bad_q) begin
      status_d = StBad;
      value_d  = '0;
    end else if (s2_ovf_q || (rounded > limit)) begin
      status_d = StRange;
      value_d  = '0;
    end else begin
      status_d = StOk;
      value_d  = s2_neg_q ? (ValueW'(0) - rounded[ValueW-1:0]) : rounded[ValueW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en_i) begin
      s1_vld_q  <= vld_i;
      s2_vld_q  <= s1_vld_q;
      out_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q     <= snap_i;
      s2_neg_q <= s1_q.neg;
      s2_mag_q <= prod[ValueW-1:0];
      s2_ovf_q <= s1_q.ovf | prod_ovf;
      s2_rup_q <= s1_q.round_up;
      s2_bad_q <= s1_q.bad;
      status_q <= status_d;
      value_q  <= value_d;
    end
  end

  assign out_vld_o = out_vld_q;
  assign value_o   = value_q;
  assign status_o  = status_q;
  assign pipe_o.s1 = s1_vld_q;
  assign pipe_o.s2 = s2_vld_q;

endmodule
